@@ rtl/tcw_pkg.sv @@
// Shared types and constants of the text console character writer.
package tcw_pkg;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NULL      = 8'd0;
    localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI  = 8'h39;
    localparam logic [7:0] PROMPT_A     = 8'h3E;
    localparam logic [7:0] PROMPT_B     = 8'h3A;
    localparam logic [7:0] AUTO_ATTR    = 8'hFF;
    localparam logic [7:0] ATTR_RESET   = 8'd7;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_ATTR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE_ATTR = 2'd2;

    typedef struct packed {
        logic [7:0] text_attr;
        logic [7:0] digit_attr;
        logic [7:0] newline_attr;
    } t_attrs;

    typedef struct packed {
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic [10:0] cursor_pos;
        logic        scrolled;
    } t_result;

endpackage

@@ rtl/tcw_screen_ram.sv @@
// Screen cell memory: one write port, one registered read port.
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tcw_engine.sv @@
// Sequencer of the console writer: clearing pass, writes, prompt, scroll sweep, reads.
module tcw_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int CELLS   = COLUMNS * ROWS,
    parameter int AW      = $clog2(CELLS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_req_type,
    input  logic [7:0]       i_char_code,
    input  logic [7:0]       i_char_attr,
    input  logic [10:0]      i_cell_index,
    input  tcw_pkg::t_attrs  i_attrs,
    input  logic             i_out_free,
    output logic             o_done,
    output tcw_pkg::t_result o_result,
    output logic             o_ram_we,
    output logic [AW-1:0]    o_ram_waddr,
    output logic [15:0]      o_ram_wdata,
    output logic             o_ram_re,
    output logic [AW-1:0]    o_ram_raddr,
    input  logic [15:0]      i_ram_rdata
);

    localparam int PW   = AW + 1;
    localparam int COLW = $clog2(COLUMNS);
    localparam logic [PW-1:0]   P_COLS     = PW'(COLUMNS);
    localparam logic [PW-1:0]   P_CELLS    = PW'(CELLS);
    localparam logic [PW-1:0]   P_LAST     = PW'(CELLS - 1);
    localparam logic [PW-1:0]   P_LASTROW  = PW'(CELLS - COLUMNS);
    localparam logic [AW-1:0]   A_COLS     = AW'(COLUMNS);
    localparam logic [AW-1:0]   A_LAST     = AW'(CELLS - 1);
    localparam logic [AW-1:0]   A_LASTROW  = AW'(CELLS - COLUMNS);
    localparam logic [COLW-1:0] C_LASTCOL  = COLW'(COLUMNS - 1);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b00000000001,
        S_IDLE     = 11'b00000000010,
        S_DECODE   = 11'b00000000100,
        S_RD_WAIT  = 11'b00000001000,
        S_BS_RD    = 11'b00000010000,
        S_BS_CLR   = 11'b00000100000,
        S_PROMPT_A = 11'b00001000000,
        S_PROMPT_B = 11'b00010000000,
        S_COPY     = 11'b00100000000,
        S_BLANK    = 11'b01000000000,
        S_DONE     = 11'b10000000000
    } t_state;

    t_state          r_state, n_state;
    logic [PW-1:0]   r_ptr, n_ptr;
    logic [AW-1:0]   r_cursor, n_cursor;
    logic [AW-1:0]   r_row_base, n_row_base;
    logic [AW-1:0]   r_line_start, n_line_start;
    logic [COLW-1:0] r_col, n_col;
    logic            r_scrolled, n_scrolled;
    logic [7:0]      r_rd_char, n_rd_char;
    logic [7:0]      r_rd_attr, n_rd_attr;
    logic            r_req;
    logic [7:0]      r_char;
    logic [7:0]      r_attr;
    logic [10:0]     r_idx;

    logic            accept;
    logic            is_digit;
    logic [7:0]      auto_attr;
    logic            idx_in_range;
    logic            bs_allowed;
    logic [PW-1:0]   copy_dst;

    assign accept       = i_in_valid && o_in_ready;
    assign o_in_ready   = (r_state == S_IDLE);
    assign is_digit     = (r_char >= tcw_pkg::CH_DIGIT_LO) && (r_char <= tcw_pkg::CH_DIGIT_HI);
    assign auto_attr    = (r_attr != tcw_pkg::AUTO_ATTR) ? r_attr :
                          (is_digit ? i_attrs.digit_attr : i_attrs.text_attr);
    assign idx_in_range = (32'(r_idx) < 32'(CELLS));
    assign bs_allowed   = ({1'b0, r_cursor} > ({1'b0, r_line_start} + PW'(2)));
    assign copy_dst     = r_ptr - P_COLS - PW'(1);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req_type;
            r_char <= i_char_code;
            r_attr <= i_char_attr;
            r_idx  <= i_cell_index;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_cursor     = r_cursor;
        n_row_base   = r_row_base;
        n_line_start = r_line_start;
        n_col        = r_col;
        n_scrolled   = r_scrolled;
        n_rd_char    = r_rd_char;
        n_rd_attr    = r_rd_attr;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_cursor;
        o_ram_wdata  = 16'd0;
        o_ram_re     = 1'b0;
        o_ram_raddr  = r_cursor;
        o_done       = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_ptr[AW-1:0];
                if (r_ptr == P_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state    = S_DECODE;
                    n_scrolled = 1'b0;
                    n_rd_char  = 8'd0;
                    n_rd_attr  = 8'd0;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                if (r_req == tcw_pkg::REQ_READ) begin
                    if (idx_in_range) begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = AW'(r_idx);
                        n_state     = S_RD_WAIT;
                    end
                end else if (r_char == tcw_pkg::CH_NEWLINE) begin
                    o_ram_we    = 1'b1;
                    o_ram_wdata = {i_attrs.newline_attr, 8'd0};
                    if (r_row_base == A_LASTROW) begin
                        n_scrolled = 1'b1;
                        n_ptr      = P_COLS;
                        n_state    = S_COPY;
                    end else begin
                        n_ptr        = {1'b0, r_row_base + A_COLS};
                        n_line_start = r_row_base + A_COLS;
                        n_state      = S_PROMPT_A;
                    end
                end else if (r_char == tcw_pkg::CH_BACKSPACE) begin
                    if (bs_allowed) begin
                        o_ram_re = 1'b1;
                        n_state  = S_BS_RD;
                    end
                end else if (r_char != tcw_pkg::CH_NULL) begin
                    o_ram_we    = 1'b1;
                    o_ram_wdata = {auto_attr, r_char};
                    if (r_cursor == A_LAST) begin
                        n_scrolled = 1'b1;
                        n_ptr      = P_COLS;
                        n_state    = S_COPY;
                    end else begin
                        n_cursor = r_cursor + AW'(1);
                        if (r_col == C_LASTCOL) begin
                            n_col      = '0;
                            n_row_base = r_row_base + A_COLS;
                        end else begin
                            n_col = r_col + COLW'(1);
                        end
                    end
                end
            end
            S_RD_WAIT: begin
                n_rd_char = i_ram_rdata[7:0];
                n_rd_attr = i_ram_rdata[15:8];
                n_state   = S_DONE;
            end
            S_BS_RD: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = {i_attrs.text_attr, i_ram_rdata[7:0]};
                n_cursor    = r_cursor - AW'(1);
                if (r_col == '0) begin
                    n_col      = C_LASTCOL;
                    n_row_base = r_row_base - A_COLS;
                end else begin
                    n_col = r_col - COLW'(1);
                end
                n_state = S_BS_CLR;
            end
            S_BS_CLR: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = {i_attrs.text_attr, 8'd0};
                n_state     = S_DONE;
            end
            S_PROMPT_A: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_ptr[AW-1:0];
                o_ram_wdata = {i_attrs.digit_attr, tcw_pkg::PROMPT_A};
                n_state     = S_PROMPT_B;
            end
            S_PROMPT_B: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_ptr[AW-1:0] + AW'(1);
                o_ram_wdata = {i_attrs.digit_attr, tcw_pkg::PROMPT_B};
                n_cursor    = r_ptr[AW-1:0] + AW'(2);
                n_row_base  = r_ptr[AW-1:0];
                n_col       = COLW'(2);
                n_state     = S_DONE;
            end
            S_COPY: begin
                o_ram_re    = (r_ptr != P_CELLS);
                o_ram_raddr = r_ptr[AW-1:0];
                o_ram_we    = (r_ptr != P_COLS);
                o_ram_waddr = copy_dst[AW-1:0];
                o_ram_wdata = i_ram_rdata;
                if (r_ptr == P_CELLS) begin
                    n_ptr   = P_LASTROW;
                    n_state = S_BLANK;
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end
            S_BLANK: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_ptr[AW-1:0];
                o_ram_wdata = {i_attrs.text_attr, 8'd0};
                if (r_ptr == P_LAST) begin
                    n_ptr        = P_LASTROW;
                    n_line_start = A_LASTROW;
                    n_state      = S_PROMPT_A;
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_ptr        <= '0;
            r_cursor     <= '0;
            r_row_base   <= '0;
            r_line_start <= '0;
            r_col        <= '0;
            r_scrolled   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ptr        <= n_ptr;
            r_cursor     <= n_cursor;
            r_row_base   <= n_row_base;
            r_line_start <= n_line_start;
            r_col        <= n_col;
            r_scrolled   <= n_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_char <= n_rd_char;
        r_rd_attr <= n_rd_attr;
    end

    assign o_result.cell_char  = r_rd_char;
    assign o_result.cell_attr  = r_rd_attr;
    assign o_result.cursor_pos = 11'(r_cursor);
    assign o_result.scrolled   = r_scrolled;

endmodule

@@ rtl/text_console_char_writer_unit.sv @@
// Top level of the text console character writer.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready     | req_type, char_code, char_attr, cell_index
//  out     | output    | o_out_valid / i_out_ready   | cell_char, cell_attr_out, cursor_pos, scrolled
//  cfg     | input     | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// Reads past the screen and backspaces refused at the prompt leave the screen memory untouched.
// A scroll copies every row up by one through the screen memory, then blanks the last row.
// After reset a clearing pass zeroes every screen cell; o_in_ready stays low meanwhile.
// A result waits in the output register; the next item is taken meanwhile, and only its
// completion stalls while the output register stays full.
module text_console_char_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_req_type,
    input  logic [7:0]                   i_char_code,
    input  logic [7:0]                   i_char_attr,
    input  logic [10:0]                  i_cell_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_cell_char,
    output logic [7:0]                   o_cell_attr_out,
    output logic [10:0]                  o_cursor_pos,
    output logic                         o_scrolled,
    input  logic                         i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                   i_cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    tcw_pkg::t_attrs  r_attrs;
    tcw_pkg::t_result r_out;
    tcw_pkg::t_result eng_result;
    logic             r_out_valid;
    logic             out_free;
    logic             eng_done;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [15:0]      ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [15:0]      ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attrs.text_attr    <= tcw_pkg::ATTR_RESET;
            r_attrs.digit_attr   <= tcw_pkg::ATTR_RESET;
            r_attrs.newline_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcw_pkg::CFG_TEXT_ATTR:    r_attrs.text_attr    <= i_cfg_data;
                tcw_pkg::CFG_DIGIT_ATTR:   r_attrs.digit_attr   <= i_cfg_data;
                tcw_pkg::CFG_NEWLINE_ATTR: r_attrs.newline_attr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done) begin
            r_out <= eng_result;
        end
    end

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .AW      (AW)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .i_char_attr  (i_char_attr),
        .i_cell_index (i_cell_index),
        .i_attrs      (r_attrs),
        .i_out_free   (out_free),
        .o_done       (eng_done),
        .o_result     (eng_result),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid     = r_out_valid;
    assign o_cell_char     = r_out.cell_char;
    assign o_cell_attr_out = r_out.cell_attr;
    assign o_cursor_pos    = r_out.cursor_pos;
    assign o_scrolled      = r_out.scrolled;

endmodule

@@ rtl/tcw_checker.sv @@
// Port-level checks of the console writer and their binding to the top level.
module tcw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [7:0]                    o_cell_char,
    input logic [7:0]                    o_cell_attr_out,
    input logic [10:0]                   o_cursor_pos,
    input logic                          o_scrolled
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cursor_pos)
            && $stable(o_cell_char) && $stable(o_scrolled))
        else $error("result changed while stalled");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input taken during clearing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transfer taken while item in progress");

    a_scroll_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |-> o_cell_char == 8'd0 && o_cell_attr_out == 8'd0)
        else $error("scrolling write returned cell data");

endmodule

bind text_console_char_writer_unit tcw_checker u_tcw_checker (.*);
